// ===== rtl/shuffled_order_navigator_macros.svh =====
// assertion macros for the shuffled order navigator checker
`ifndef SHUFFLED_ORDER_NAVIGATOR_MACROS_SVH
`define SHUFFLED_ORDER_NAVIGATOR_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define SON_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("son assertion failed");

// next-cycle implication, sampled on clk, off during reset
`define SON_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("son assertion failed");

`endif

// ===== rtl/son_pkg.sv =====
// shared constants, codes and transfer types of the shuffled order navigator
`default_nettype none
package son_pkg;
	localparam int MAX_TRACKS = 256;
	localparam int ADDR_W     = $clog2(MAX_TRACKS);
	localparam int CNT_W      = 9;
	localparam int ENTRY_W    = 8;
	localparam int CMD_W      = 3;
	localparam int SEED_W     = 32;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 32;

	localparam int DIV_BITS   = 4;
	localparam int DIV_STEPS  = SEED_W / DIV_BITS;
	localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

	localparam logic [SEED_W-1:0] SEED_DEFAULT = 32'd2463534242;

	localparam logic [CMD_W-1:0] CMD_NEXT        = 3'd0;
	localparam logic [CMD_W-1:0] CMD_PREV        = 3'd1;
	localparam logic [CMD_W-1:0] CMD_SHUFFLE_ON  = 3'd2;
	localparam logic [CMD_W-1:0] CMD_SHUFFLE_OFF = 3'd3;
	localparam logic [CMD_W-1:0] CMD_TOGGLE      = 3'd4;

	localparam logic [CFG_IDX_W-1:0] REG_TRACK_COUNT = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_RANDOM_SEED = 1'd1;

	typedef struct packed {
		logic [CMD_W-1:0]   command;
		logic [ENTRY_W-1:0] current_index;
	} req_t;

	typedef struct packed {
		logic [ENTRY_W-1:0] track_index;
		logic               track_valid;
		logic               shuffle_active;
	} res_t;
endpackage
`default_nettype wire

// ===== rtl/son_req_if.sv =====
// command channel: valid, ready and the command item
`default_nettype none
interface son_req_if;
	logic            valid;
	logic            ready;
	son_pkg::req_t   data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== rtl/son_res_if.sv =====
// result channel: valid, ready and the result item
`default_nettype none
interface son_res_if;
	logic            valid;
	logic            ready;
	son_pkg::res_t   data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== rtl/shuffled_order_navigator.sv =====
// shuffled order navigator top level: order memory, scan, shuffle sequencer
// next/prev: with shuffle on, scan the order memory, then fetch the neighbour
// shuffle on: identity fill, then draw, 8-step modulo, swap
// one command at a time; the 256-entry order memory's single read port sets the pace
// after reset a pass loads the identity into the memory; request.ready stays low
// reset clears control state, the shuffle flag, track count and the generator to its seed
`default_nettype none
module shuffled_order_navigator (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_we,
	input  wire logic [son_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [son_pkg::CFG_DATA_W-1:0]  cfg_data,
	son_req_if.sink                              request,
	son_res_if.source                            result
);
	localparam logic [3:0] ST_INIT   = 4'd0;
	localparam logic [3:0] ST_IDLE   = 4'd1;
	localparam logic [3:0] ST_SCAN   = 4'd2;
	localparam logic [3:0] ST_FETCH  = 4'd3;
	localparam logic [3:0] ST_DRAW   = 4'd4;
	localparam logic [3:0] ST_DIV    = 4'd5;
	localparam logic [3:0] ST_SWAP_A = 4'd6;
	localparam logic [3:0] ST_SWAP_B = 4'd7;
	localparam logic [3:0] ST_DONE   = 4'd8;

	logic [son_pkg::ENTRY_W-1:0] order_mem [son_pkg::MAX_TRACKS];
	logic [son_pkg::ENTRY_W-1:0] rd_data_q;
	logic                        rd_en;
	logic [son_pkg::ADDR_W-1:0]  rd_addr;
	logic                        wr_en;
	logic [son_pkg::ADDR_W-1:0]  wr_addr;
	logic [son_pkg::ENTRY_W-1:0] wr_data;

	logic [3:0]                     state_q;
	logic [son_pkg::CNT_W-1:0]      cnt_q;
	logic [son_pkg::CNT_W-1:0]      lim_q;
	logic                           shuf_pend_q;
	logic                           flag_q;
	logic [son_pkg::CNT_W-1:0]      track_count_q;
	logic [son_pkg::SEED_W-1:0]     rng_q;
	logic [son_pkg::ENTRY_W-1:0]    cur_q;
	logic                           fwd_q;
	logic                           scan_vld_s1;
	logic [son_pkg::ADDR_W-1:0]     scan_pos_s1;
	logic [son_pkg::SEED_W-1:0]     div_q;
	logic [son_pkg::ENTRY_W-1:0]    rem_q;
	logic [son_pkg::DIV_CNT_W-1:0]  div_cnt_q;
	logic [son_pkg::ADDR_W-1:0]     j_q;
	logic [son_pkg::ENTRY_W-1:0]    ti_q;
	logic [son_pkg::ENTRY_W-1:0]    res_idx_q;
	logic                           res_vld_q;
	logic                           out_valid_q;
	son_pkg::res_t                  out_data_q;

	logic [son_pkg::CNT_W-1:0]      eff_n;
	logic                           req_xfer;
	logic                           out_free;
	logic [son_pkg::SEED_W-1:0]     rng_nx;
	logic [son_pkg::CNT_W-1:0]      divisor;
	logic [son_pkg::ENTRY_W-1:0]    rem_nx;
	logic                           match;
	logic [son_pkg::CNT_W-1:0]      pos_ext;
	logic [son_pkg::ADDR_W-1:0]     nb_addr;
	logic [son_pkg::CNT_W-1:0]      cur_inc;
	logic [son_pkg::ENTRY_W-1:0]    arith_idx;

	function automatic logic [son_pkg::SEED_W-1:0] xorshift(
		input logic [son_pkg::SEED_W-1:0] s
	);
		logic [son_pkg::SEED_W-1:0] x;
		x = s;
		x = x ^ (x << 13);
		x = x ^ (x >> 17);
		x = x ^ (x << 5);
		return x;
	endfunction

	// restoring remainder, DIV_BITS dividend bits per call, msb first
	function automatic logic [son_pkg::ENTRY_W-1:0] mod_step(
		input logic [son_pkg::ENTRY_W-1:0]  rem,
		input logic [son_pkg::DIV_BITS-1:0] bits,
		input logic [son_pkg::CNT_W-1:0]    d
	);
		logic [son_pkg::CNT_W-1:0]   t;
		logic [son_pkg::ENTRY_W-1:0] r;
		r = rem;
		for (int k = son_pkg::DIV_BITS - 1; k >= 0; k--) begin
			t = {r, bits[k]};
			if (t >= d) begin
				t = t - d;
			end
			r = t[son_pkg::ENTRY_W-1:0];
		end
		return r;
	endfunction

	assign eff_n = (track_count_q > son_pkg::CNT_W'(son_pkg::MAX_TRACKS)) ?
		son_pkg::CNT_W'(son_pkg::MAX_TRACKS) : track_count_q;

	assign request.ready = (state_q == ST_IDLE);
	assign req_xfer      = request.valid && request.ready;
	assign out_free      = !out_valid_q || result.ready;
	assign result.valid  = out_valid_q;
	assign result.data   = out_data_q;

	assign rng_nx  = xorshift(rng_q);
	assign divisor = cnt_q + son_pkg::CNT_W'(1);
	assign rem_nx  = mod_step(rem_q, div_q[son_pkg::SEED_W-1 -: son_pkg::DIV_BITS], divisor);

	assign match   = scan_vld_s1 && (rd_data_q == cur_q);
	assign pos_ext = {1'b0, scan_pos_s1};
	assign cur_inc = {1'b0, cur_q} + son_pkg::CNT_W'(1);

	always_comb begin
		if (fwd_q) begin
			nb_addr = ((pos_ext + son_pkg::CNT_W'(1)) < lim_q) ?
				scan_pos_s1 + son_pkg::ADDR_W'(1) : '0;
			arith_idx = (cur_inc >= lim_q) ? '0 : cur_inc[son_pkg::ENTRY_W-1:0];
		end else begin
			nb_addr = (scan_pos_s1 != '0) ? scan_pos_s1 - son_pkg::ADDR_W'(1) :
				son_pkg::ADDR_W'(lim_q - son_pkg::CNT_W'(1));
			arith_idx = (cur_q == '0) ? son_pkg::ENTRY_W'(lim_q - son_pkg::CNT_W'(1)) :
				cur_q - son_pkg::ENTRY_W'(1);
		end
	end

	// memory port control
	always_comb begin
		rd_en   = 1'b0;
		rd_addr = '0;
		wr_en   = 1'b0;
		wr_addr = '0;
		wr_data = '0;
		case (state_q)
			ST_INIT: begin
				if (cnt_q < lim_q) begin
					wr_en   = 1'b1;
					wr_addr = cnt_q[son_pkg::ADDR_W-1:0];
					wr_data = son_pkg::ENTRY_W'(cnt_q);
				end
			end
			ST_SCAN: begin
				if (match) begin
					rd_en   = 1'b1;
					rd_addr = nb_addr;
				end else if (flag_q && cnt_q < lim_q) begin
					rd_en   = 1'b1;
					rd_addr = cnt_q[son_pkg::ADDR_W-1:0];
				end
			end
			ST_DRAW: begin
				rd_en   = 1'b1;
				rd_addr = cnt_q[son_pkg::ADDR_W-1:0];
			end
			ST_DIV: begin
				if (div_cnt_q == son_pkg::DIV_CNT_W'(son_pkg::DIV_STEPS - 1)) begin
					rd_en   = 1'b1;
					rd_addr = son_pkg::ADDR_W'(rem_nx);
				end
			end
			ST_SWAP_A: begin
				wr_en   = 1'b1;
				wr_addr = cnt_q[son_pkg::ADDR_W-1:0];
				wr_data = rd_data_q;
			end
			ST_SWAP_B: begin
				wr_en   = 1'b1;
				wr_addr = j_q;
				wr_data = ti_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			order_mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= order_mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_INIT;
			cnt_q         <= '0;
			lim_q         <= son_pkg::CNT_W'(son_pkg::MAX_TRACKS);
			shuf_pend_q   <= 1'b0;
			flag_q        <= 1'b0;
			track_count_q <= '0;
			rng_q         <= son_pkg::SEED_DEFAULT;
			cur_q         <= '0;
			fwd_q         <= 1'b0;
			scan_vld_s1   <= 1'b0;
			scan_pos_s1   <= '0;
			div_q         <= '0;
			rem_q         <= '0;
			div_cnt_q     <= '0;
			j_q           <= '0;
			ti_q          <= '0;
			res_idx_q     <= '0;
			res_vld_q     <= 1'b0;
			out_valid_q   <= 1'b0;
			out_data_q    <= '0;
		end else begin
			scan_vld_s1 <= (state_q == ST_SCAN) && !match && flag_q && (cnt_q < lim_q);

			if (out_valid_q && result.ready && (state_q != ST_DONE)) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				ST_INIT: begin
					if (cnt_q < lim_q) begin
						cnt_q <= cnt_q + son_pkg::CNT_W'(1);
					end else if (shuf_pend_q) begin
						shuf_pend_q <= 1'b0;
						if (lim_q < son_pkg::CNT_W'(2)) begin
							state_q <= ST_DONE;
						end else begin
							cnt_q   <= lim_q - son_pkg::CNT_W'(1);
							state_q <= ST_DRAW;
						end
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (req_xfer) begin
						lim_q     <= eff_n;
						cur_q     <= request.data.current_index;
						fwd_q     <= (request.data.command == son_pkg::CMD_NEXT);
						cnt_q     <= '0;
						res_idx_q <= '0;
						res_vld_q <= 1'b0;
						case (request.data.command)
							son_pkg::CMD_NEXT, son_pkg::CMD_PREV: begin
								state_q <= (eff_n == '0) ? ST_DONE : ST_SCAN;
							end
							son_pkg::CMD_SHUFFLE_ON: begin
								flag_q      <= 1'b1;
								shuf_pend_q <= 1'b1;
								state_q     <= ST_INIT;
							end
							son_pkg::CMD_SHUFFLE_OFF: begin
								flag_q  <= 1'b0;
								state_q <= ST_DONE;
							end
							son_pkg::CMD_TOGGLE: begin
								if (flag_q) begin
									flag_q  <= 1'b0;
									state_q <= ST_DONE;
								end else begin
									flag_q      <= 1'b1;
									shuf_pend_q <= 1'b1;
									state_q     <= ST_INIT;
								end
							end
							default: begin
								state_q <= ST_DONE;
							end
						endcase
					end
				end
				ST_SCAN: begin
					if (match) begin
						state_q <= ST_FETCH;
					end else if (flag_q && cnt_q < lim_q) begin
						scan_pos_s1 <= cnt_q[son_pkg::ADDR_W-1:0];
						cnt_q       <= cnt_q + son_pkg::CNT_W'(1);
					end else if (!scan_vld_s1) begin
						// index not in the table, or shuffle off
						res_idx_q <= arith_idx;
						res_vld_q <= 1'b1;
						state_q   <= ST_DONE;
					end
				end
				ST_FETCH: begin
					res_idx_q <= rd_data_q;
					res_vld_q <= 1'b1;
					state_q   <= ST_DONE;
				end
				ST_DRAW: begin
					rng_q     <= rng_nx;
					div_q     <= rng_nx;
					rem_q     <= '0;
					div_cnt_q <= '0;
					state_q   <= ST_DIV;
				end
				ST_DIV: begin
					rem_q     <= rem_nx;
					div_q     <= div_q << son_pkg::DIV_BITS;
					div_cnt_q <= div_cnt_q + son_pkg::DIV_CNT_W'(1);
					if (div_cnt_q == son_pkg::DIV_CNT_W'(son_pkg::DIV_STEPS - 1)) begin
						ti_q    <= rd_data_q;
						j_q     <= son_pkg::ADDR_W'(rem_nx);
						state_q <= ST_SWAP_A;
					end
				end
				ST_SWAP_A: begin
					state_q <= ST_SWAP_B;
				end
				ST_SWAP_B: begin
					if (cnt_q == son_pkg::CNT_W'(1)) begin
						state_q <= ST_DONE;
					end else begin
						cnt_q   <= cnt_q - son_pkg::CNT_W'(1);
						state_q <= ST_DRAW;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						out_valid_q                <= 1'b1;
						out_data_q.track_index     <= res_idx_q;
						out_data_q.track_valid     <= res_vld_q;
						out_data_q.shuffle_active  <= flag_q;
						state_q                    <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase

			// configuration writes
			if (cfg_we) begin
				case (cfg_index)
					son_pkg::REG_TRACK_COUNT: begin
						track_count_q <= cfg_data[son_pkg::CNT_W-1:0];
					end
					son_pkg::REG_RANDOM_SEED: begin
						rng_q <= (cfg_data[son_pkg::SEED_W-1:0] == '0) ?
							son_pkg::SEED_DEFAULT : cfg_data[son_pkg::SEED_W-1:0];
					end
					default: begin
					end
				endcase
			end
		end
	end
endmodule
`default_nettype wire

// ===== rtl/son_checker.sv =====
// port-level checks for the shuffled order navigator, bound to the top level
`default_nettype none
`include "shuffled_order_navigator_macros.svh"
module son_checker (
	input wire logic          clk,
	input wire logic          arst_n,
	input wire logic          req_valid,
	input wire logic          req_ready,
	input wire son_pkg::req_t req_data,
	input wire logic          res_valid,
	input wire logic          res_ready,
	input wire son_pkg::res_t res_data
);
	logic req_xfer;
	assign req_xfer = req_valid && req_ready && (req_data.command == req_data.command);

	// a stalled result keeps its payload
	`SON_ASSERT_NEXT(a_res_hold, res_valid && !res_ready, res_valid && $stable(res_data))
	// one command at a time: busy right after a transfer
	`SON_ASSERT_NEXT(a_busy_after_req, req_xfer, !req_ready)
	// an invalid result carries index zero
	`SON_ASSERT_NOW(a_invalid_zero, res_valid && !res_data.track_valid,
		res_data.track_index == '0)
endmodule

bind shuffled_order_navigator son_checker u_son_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (request.valid),
	.req_ready (request.ready),
	.req_data  (request.data),
	.res_valid (result.valid),
	.res_ready (result.ready),
	.res_data  (result.data)
);
`default_nettype wire

// ===== sim/shuffled_order_navigator_tb.sv =====
`timescale 1ns / 100ps
// testbench for the shuffled order navigator: directed and random commands checked against a predictor
module shuffled_order_navigator_tb;
	import son_pkg::*;

	localparam int CLK_PERIOD   = 12;
	localparam int RESET_CYCLES = 10;
	localparam int DRAIN_CYCLES = 8;
	localparam int CYCLE_LIMIT  = 1_000_000;
	localparam int PHASES       = 16;

	localparam logic [CMD_W-1:0] CMD_SPARE_FIRST = CMD_TOGGLE + 3'd1;
	localparam logic [CMD_W-1:0] CMD_SPARE_LAST  = '1;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	son_req_if req_ch ();
	son_res_if res_ch ();

	shuffled_order_navigator dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.request   (req_ch),
		.result    (res_ch)
	);

	// predictor state
	logic [ENTRY_W-1:0] order_tbl [MAX_TRACKS];
	logic               shuffle_q;
	logic [SEED_W-1:0]  rng_state;
	logic [CNT_W-1:0]   tracks_reg;

	req_t cmd_queue [$];
	res_t expected_results [$];
	int   outstanding;
	int   mismatches;
	int   results_seen;
	int   cycles;
	int   send_idle_pct;
	int   recv_stall_pct;
	bit   req_moved;

	initial clk = 1'b0;
	always #(CLK_PERIOD / 2) clk = ~clk;

	function automatic int live_tracks();
		return (tracks_reg > MAX_TRACKS) ? MAX_TRACKS : int'(tracks_reg);
	endfunction

	function automatic logic [SEED_W-1:0] xorshift_draw();
		logic [SEED_W-1:0] x;
		x = rng_state;
		x ^= x << 13;
		x ^= x >> 17;
		x ^= x << 5;
		rng_state = x;
		return x;
	endfunction

	function automatic void deal_order();
		int n;
		int unsigned span;
		int unsigned j;
		logic [ENTRY_W-1:0] t;
		n = live_tracks();
		shuffle_q = 1'b1;
		for (int i = 0; i < n; i++)
			order_tbl[i] = ENTRY_W'(i);
		for (int i = n - 1; i > 0; i--) begin
			span = i + 1;
			j = xorshift_draw() % span;
			t = order_tbl[i];
			order_tbl[i] = order_tbl[j];
			order_tbl[j] = t;
		end
	endfunction

	function automatic logic [ENTRY_W-1:0] step_track(logic [ENTRY_W-1:0] cur, bit fwd);
		int n;
		int c;
		n = live_tracks();
		c = cur;
		if (shuffle_q) begin
			for (int i = 0; i < n; i++) begin
				if (order_tbl[i] == cur) begin
					if (fwd)
						return (i + 1 < n) ? order_tbl[i + 1] : order_tbl[0];
					return (i > 0) ? order_tbl[i - 1] : order_tbl[n - 1];
				end
			end
		end
		if (fwd)
			return (c + 1 >= n) ? '0 : ENTRY_W'(c + 1);
		return (c == 0) ? ENTRY_W'(n - 1) : ENTRY_W'(c - 1);
	endfunction

	function automatic res_t predict_navigation(req_t item);
		res_t r;
		r = '0;
		case (item.command)
			CMD_NEXT, CMD_PREV: begin
				if (live_tracks() != 0) begin
					r.track_index = step_track(item.current_index, item.command == CMD_NEXT);
					r.track_valid = 1'b1;
				end
			end
			CMD_SHUFFLE_ON: deal_order();
			CMD_SHUFFLE_OFF: shuffle_q = 1'b0;
			CMD_TOGGLE: begin
				if (shuffle_q)
					shuffle_q = 1'b0;
				else
					deal_order();
			end
			default: ;
		endcase
		r.shuffle_active = shuffle_q;
		return r;
	endfunction

	task automatic report_mismatch(string what, int unsigned got, int unsigned want);
		$display("mismatch on result %0d: %0s got %0d expected %0d", results_seen, what, got, want);
		mismatches++;
	endtask

	task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_TRACK_COUNT)
			tracks_reg = value[CNT_W-1:0];
		else
			rng_state = (value == '0) ? SEED_DEFAULT : value;
	endtask

	task automatic queue_command(logic [CMD_W-1:0] op, logic [ENTRY_W-1:0] idx);
		req_t r;
		r.command = op;
		r.current_index = idx;
		cmd_queue.push_back(r);
		outstanding++;
	endtask

	task automatic wait_all_done();
		while (outstanding != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic queue_random_commands(int count, int n, bit heavy);
		logic [CMD_W-1:0] op;
		logic [ENTRY_W-1:0] idx;
		int roll;
		repeat (count) begin
			roll = $urandom_range(99);
			if (heavy) begin
				if (roll < 47) op = CMD_NEXT;
				else if (roll < 94) op = CMD_PREV;
				else if (roll < 96) op = CMD_SHUFFLE_ON;
				else if (roll < 98) op = CMD_SHUFFLE_OFF;
				else if (roll < 99) op = CMD_TOGGLE;
				else op = CMD_W'($urandom_range(CMD_SPARE_LAST, CMD_SPARE_FIRST));
			end else begin
				if (roll < 35) op = CMD_NEXT;
				else if (roll < 65) op = CMD_PREV;
				else if (roll < 75) op = CMD_SHUFFLE_ON;
				else if (roll < 82) op = CMD_SHUFFLE_OFF;
				else if (roll < 92) op = CMD_TOGGLE;
				else op = CMD_W'($urandom_range(CMD_SPARE_LAST, CMD_SPARE_FIRST));
			end
			if (n > 0 && $urandom_range(9) < 8)
				idx = ENTRY_W'($urandom_range(n - 1));
			else
				idx = ENTRY_W'($urandom_range(255));
			queue_command(op, idx);
		end
	endtask

	// driver
	always @(negedge clk) begin
		if (!arst_n) begin
			req_ch.valid <= 1'b0;
			res_ch.ready <= 1'b0;
		end else begin
			if (!req_ch.valid || req_moved) begin
				if (cmd_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					req_ch.valid <= 1'b1;
					req_ch.data <= cmd_queue.pop_front();
				end else
					req_ch.valid <= 1'b0;
			end
			res_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
		end
		req_moved = 1'b0;
	end

	// monitor
	always @(posedge clk) begin
		res_t want;
		res_t got;
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
		if (arst_n && req_ch.valid && req_ch.ready) begin
			expected_results.push_back(predict_navigation(req_ch.data));
			req_moved = 1'b1;
		end
		if (arst_n && res_ch.valid && res_ch.ready) begin
			got = res_ch.data;
			if (expected_results.size() == 0)
				report_mismatch("unexpected transfer", got, 0);
			else begin
				want = expected_results.pop_front();
				if (got.track_index !== want.track_index)
					report_mismatch("track_index", got.track_index, want.track_index);
				if (got.track_valid !== want.track_valid)
					report_mismatch("track_valid", got.track_valid, want.track_valid);
				if (got.shuffle_active !== want.shuffle_active)
					report_mismatch("shuffle_active", got.shuffle_active, want.shuffle_active);
				outstanding--;
			end
			results_seen++;
		end
	end

	initial begin
		logic [CFG_DATA_W-1:0] word;
		int cnt;
		int eff;
		int items;
		bit heavy;

		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		req_ch.valid = 1'b0;
		req_ch.data = '0;
		res_ch.ready = 1'b0;
		req_moved = 1'b0;
		outstanding = 0;
		mismatches = 0;
		results_seen = 0;
		cycles = 0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		shuffle_q = 1'b0;
		rng_state = SEED_DEFAULT;
		tracks_reg = '0;
		for (int i = 0; i < MAX_TRACKS; i++)
			order_tbl[i] = ENTRY_W'(i);

		repeat (RESET_CYCLES) @(negedge clk);
		arst_n = 1'b1;

		// empty playlist straight out of reset
		queue_command(CMD_NEXT, 8'd0);
		queue_command(CMD_PREV, 8'd255);
		queue_command(CMD_SHUFFLE_ON, 8'd0);
		queue_command(CMD_NEXT, 8'd5);
		queue_command(CMD_TOGGLE, 8'd0);
		queue_command(CMD_TOGGLE, 8'd0);
		queue_command(CMD_SHUFFLE_OFF, 8'd0);
		queue_command(CMD_SPARE_FIRST, 8'ha5);
		queue_command(CMD_SPARE_FIRST + 3'd1, 8'h5a);
		queue_command(CMD_SPARE_LAST, 8'hff);
		wait_all_done();

		// single track
		cfg_write(REG_TRACK_COUNT, 32'd1);
		queue_command(CMD_NEXT, 8'd0);
		queue_command(CMD_PREV, 8'd0);
		queue_command(CMD_NEXT, 8'd200);
		queue_command(CMD_SHUFFLE_ON, 8'd0);
		queue_command(CMD_NEXT, 8'd0);
		queue_command(CMD_PREV, 8'd0);
		wait_all_done();

		// count saturates, first shuffle draws from the reset seed
		cfg_write(REG_TRACK_COUNT, 32'd511);
		queue_command(CMD_SHUFFLE_ON, 8'd0);
		queue_command(CMD_NEXT, 8'd255);
		queue_command(CMD_PREV, 8'd0);
		queue_command(CMD_SHUFFLE_ON, 8'd0);
		queue_command(CMD_NEXT, 8'd128);
		queue_command(CMD_PREV, 8'd255);
		queue_command(CMD_SHUFFLE_OFF, 8'd0);
		queue_command(CMD_NEXT, 8'd255);
		queue_command(CMD_PREV, 8'd0);
		wait_all_done();

		for (int p = 0; p < PHASES; p++) begin
			case (p % 8)
				0: cnt = 2;
				1: cnt = 0;
				2: cnt = $urandom_range(16, 3);
				3: cnt = (p < 8) ? 511 : 256;
				4: cnt = 1;
				5: cnt = $urandom_range(40, 3);
				6: cnt = (p < 8) ? 255 : $urandom_range(510, 257);
				default: cnt = $urandom_range(8, 2);
			endcase
			word = $urandom();
			word[CNT_W-1:0] = CNT_W'(cnt);
			cfg_write(REG_TRACK_COUNT, word);
			case (p % 5)
				0: cfg_write(REG_RANDOM_SEED, 32'd0);
				1: cfg_write(REG_RANDOM_SEED, 32'hffff_ffff);
				2: cfg_write(REG_RANDOM_SEED, $urandom());
				3: ;
				default: cfg_write(REG_RANDOM_SEED, 32'd1);
			endcase
			case (p % 4)
				0: begin
					send_idle_pct = 0;
					recv_stall_pct = 0;
				end
				1: begin
					send_idle_pct = 77;
					recv_stall_pct = 0;
				end
				2: begin
					send_idle_pct = 0;
					recv_stall_pct = 77;
				end
				default: begin
					send_idle_pct = 38;
					recv_stall_pct = 38;
				end
			endcase
			eff = (cnt > MAX_TRACKS) ? MAX_TRACKS : cnt;
			heavy = (eff >= 64);
			items = heavy ? 20 : 40;
			if (p == 5 || p == 13) begin
				queue_random_commands(items / 2, eff, heavy);
				wait_all_done();
				queue_random_commands(items - items / 2, eff, heavy);
			end else
				queue_random_commands(items, eff, heavy);
			// leave shuffle on so the next count change meets a stale table
			if (p % 2 == 0)
				queue_command(CMD_SHUFFLE_ON, ENTRY_W'($urandom_range(255)));
			wait_all_done();
		end

		if (mismatches == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end
endmodule
